>>> src/isotf_pkg.sv
// Shared widths, queue default and the decoded timestamp record for the formatter.
package isotf_pkg;

  localparam int unsigned USEC_W          = 58;
  localparam int unsigned CHAR_W          = 7;
  localparam int unsigned NUM_DIGITS      = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Decimal digits in text order: year(4) month(2) day(2) hour(2) min(2) sec(2) frac(2).
  typedef struct packed {
    logic [NUM_DIGITS-1:0][3:0] dig;
    logic                       has_frac;
  } entry_t;

endpackage

>>> src/isotf_front.sv
// Front end: input holding register, constant divider and calendar/time decode.
module isotf_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [isotf_pkg::USEC_W-1:0]     in_epoch_usec,
  output logic                             ent_valid,
  input  logic                             ent_ready,
  output isotf_pkg::entry_t                ent
);
  import isotf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_YOE1, ST_YOE2, ST_DOY, ST_MON, ST_DIG, ST_PACK, ST_OUT
  } state_t;

  typedef enum logic [1:0] {DV_USEC, DV_DAY, DV_ERA} div_sel_t;

  localparam logic [USEC_W-1:0] USEC_MAX     = 58'd253402300799999999;
  localparam logic [19:0]       ONE_SEC_USEC = 20'd1000000;
  localparam logic [19:0]       SEC_PER_DAY  = 20'd86400;
  localparam logic [19:0]       DAYS_PER_ERA = 20'd146097;
  localparam logic [21:0]       EPOCH_SHIFT  = 22'd719468;

  // Reciprocals: x / C == (x * ceil(2^S / C)) >> S, S = width(x) + ceil(log2 C).
  localparam longint unsigned M1460 = ((64'd1 << 29) + 64'd1459) / 64'd1460;
  localparam longint unsigned M365  = ((64'd1 << 27) + 64'd364) / 64'd365;
  localparam longint unsigned M3600 = ((64'd1 << 29) + 64'd3599) / 64'd3600;
  localparam longint unsigned M60   = ((64'd1 << 18) + 64'd59) / 64'd60;
  localparam longint unsigned MCENT = ((64'd1 << 34) + 64'd9999) / 64'd10000;
  localparam longint unsigned M100  = ((64'd1 << 21) + 64'd99) / 64'd100;
  localparam longint unsigned M10   = ((64'd1 << 11) + 64'd9) / 64'd10;

  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] s;
    case (m)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] bin2dig(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  tn;
    p  = 15'(v) * 15'(M10);
    tn = p[14:11];
    return {tn, 4'(v - 7'(tn) * 7'd10)};
  endfunction

  state_t            state_r;
  div_sel_t          div_sel_r;
  logic [2:0]        cnt_r;
  logic [63:0]       q_r;
  logic [19:0]       r_r;
  logic [USEC_W-1:0] hold_r;
  logic              hold_v_r;
  logic [19:0]       frac_r;
  logic [16:0]       sod_r;
  logic [4:0]        era_r;
  logic [17:0]       doe_r;
  logic [17:0]       t_r;
  logic [4:0]        hour_r;
  logic [11:0]       rem_r;
  logic [6:0]        cent_r;
  logic              has_frac_r;
  logic [8:0]        yoe_r;
  logic [5:0]        min_r;
  logic [5:0]        sec_r;
  logic [8:0]        doy_r;
  logic [13:0]       year_r;
  logic [3:0]        month_r;
  logic [4:0]        day_r;
  logic [6:0]        yhi_r;
  logic [6:0]        ylo_r;
  entry_t            ent_r;

  logic [19:0]       dsor;
  logic [20:0]       rw;
  logic [20:0]       rt;
  logic [63:0]       qw;
  logic [19:0]       r_step;
  logic [63:0]       q_step;
  logic [USEC_W-1:0] us_sat;
  logic              start;
  logic [21:0]       z;
  logic [36:0]       p1460;
  logic [2:0]        q36524;
  logic [18:0]       t_c;
  logic [34:0]       phr;
  logic [4:0]        hour_c;
  logic [40:0]       pcent;
  logic [36:0]       p365;
  logic [24:0]       pmin;
  logic [1:0]        c100;
  logic [17:0]       yoe_days;
  logic [3:0]        mp;
  logic [3:0]        month_c;
  logic [28:0]       pyhi;
  logic [6:0]        yhi_c;
  logic [7:0]        d_y0, d_y1, d_mo, d_dy, d_hr, d_mi, d_se, d_ce;

  // Radix-256 restoring divider by the selected constant.
  always_comb begin
    case (div_sel_r)
      DV_USEC: dsor = ONE_SEC_USEC;
      DV_DAY:  dsor = SEC_PER_DAY;
      DV_ERA:  dsor = DAYS_PER_ERA;
      default: dsor = ONE_SEC_USEC;
    endcase
    rw = {1'b0, r_r};
    qw = q_r;
    rt = '0;
    for (int i = 0; i < 8; i++) begin
      rt = {rw[19:0], qw[63]};
      qw = {qw[62:0], 1'b0};
      if (rt >= {1'b0, dsor}) begin
        rt    = rt - {1'b0, dsor};
        qw[0] = 1'b1;
      end
      rw = rt;
    end
    r_step = rw[19:0];
    q_step = qw;
  end

  assign us_sat = (hold_r > USEC_MAX) ? USEC_MAX : hold_r;
  assign start  = hold_v_r && ((state_r == ST_IDLE) || ((state_r == ST_OUT) && ent_ready));
  assign z      = q_step[21:0] + EPOCH_SHIFT;

  always_comb begin
    p1460  = 37'(doe_r) * 37'(M1460);
    q36524 = 3'(doe_r >= 18'd36524) + 3'(doe_r >= 18'd73048) +
             3'(doe_r >= 18'd109572) + 3'(doe_r >= 18'd146096);
    t_c    = 19'(doe_r) - 19'(p1460[35:29]) + 19'(q36524) - 19'(doe_r == 18'd146096);
    phr    = 35'(sod_r) * 35'(M3600);
    hour_c = phr[33:29];
    pcent  = 41'(frac_r) * 41'(MCENT);
    p365   = 37'(t_r) * 37'(M365);
    pmin   = 25'(rem_r) * 25'(M60);
    c100   = 2'(yoe_r >= 9'd100) + 2'(yoe_r >= 9'd200) + 2'(yoe_r >= 9'd300);
    yoe_days = 18'(yoe_r) * 18'd365 + 18'(yoe_r[8:2]) - 18'(c100);
    mp = '0;
    for (int k = 1; k < 12; k++) begin
      if (doy_r >= month_start(4'(k))) mp = 4'(k);
    end
    month_c = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
    pyhi    = 29'(year_r) * 29'(M100);
    yhi_c   = pyhi[27:21];
    d_y0    = bin2dig(yhi_r);
    d_y1    = bin2dig(ylo_r);
    d_mo    = bin2dig(7'(month_r));
    d_dy    = bin2dig(7'(day_r));
    d_hr    = bin2dig(7'(hour_r));
    d_mi    = bin2dig(7'(min_r));
    d_se    = bin2dig(7'(sec_r));
    d_ce    = bin2dig(cent_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      hold_v_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        hold_r   <= in_epoch_usec;
        hold_v_r <= 1'b1;
      end
      if (start) begin
        q_r       <= {6'b0, us_sat};
        r_r       <= '0;
        cnt_r     <= 3'd7;
        div_sel_r <= DV_USEC;
        hold_v_r  <= 1'b0;
        state_r   <= ST_DIV;
      end else begin
        case (state_r)
          ST_IDLE: ;
          ST_DIV: begin
            if (cnt_r != 3'd0) begin
              q_r   <= q_step;
              r_r   <= r_step;
              cnt_r <= cnt_r - 3'd1;
            end else begin
              case (div_sel_r)
                DV_USEC: begin
                  frac_r    <= r_step;
                  q_r       <= {2'b0, q_step[37:0], 24'b0};
                  r_r       <= '0;
                  cnt_r     <= 3'd4;
                  div_sel_r <= DV_DAY;
                end
                DV_DAY: begin
                  sod_r     <= r_step[16:0];
                  q_r       <= {2'b0, z, 40'b0};
                  r_r       <= '0;
                  cnt_r     <= 3'd2;
                  div_sel_r <= DV_ERA;
                end
                default: begin
                  era_r   <= q_step[4:0];
                  doe_r   <= r_step[17:0];
                  state_r <= ST_YOE1;
                end
              endcase
            end
          end
          ST_YOE1: begin
            t_r        <= t_c[17:0];
            hour_r     <= hour_c;
            rem_r      <= 12'(sod_r - 17'(hour_c) * 17'd3600);
            cent_r     <= pcent[40:34];
            has_frac_r <= (frac_r != 20'd0);
            state_r    <= ST_YOE2;
          end
          ST_YOE2: begin
            yoe_r   <= p365[35:27];
            min_r   <= pmin[23:18];
            state_r <= ST_DOY;
          end
          ST_DOY: begin
            doy_r   <= 9'(doe_r - yoe_days);
            year_r  <= 14'(yoe_r) + 14'(era_r) * 14'd400;
            sec_r   <= 6'(rem_r - 12'(min_r) * 12'd60);
            state_r <= ST_MON;
          end
          ST_MON: begin
            month_r <= month_c;
            day_r   <= 5'(doy_r - month_start(mp) + 9'd1);
            year_r  <= year_r + 14'(month_c <= 4'd2);
            state_r <= ST_DIG;
          end
          ST_DIG: begin
            yhi_r   <= yhi_c;
            ylo_r   <= 7'(year_r - 14'(yhi_c) * 14'd100);
            state_r <= ST_PACK;
          end
          ST_PACK: begin
            ent_r.dig[0]    <= d_y0[7:4];
            ent_r.dig[1]    <= d_y0[3:0];
            ent_r.dig[2]    <= d_y1[7:4];
            ent_r.dig[3]    <= d_y1[3:0];
            ent_r.dig[4]    <= d_mo[7:4];
            ent_r.dig[5]    <= d_mo[3:0];
            ent_r.dig[6]    <= d_dy[7:4];
            ent_r.dig[7]    <= d_dy[3:0];
            ent_r.dig[8]    <= d_hr[7:4];
            ent_r.dig[9]    <= d_hr[3:0];
            ent_r.dig[10]   <= d_mi[7:4];
            ent_r.dig[11]   <= d_mi[3:0];
            ent_r.dig[12]   <= d_se[7:4];
            ent_r.dig[13]   <= d_se[3:0];
            ent_r.dig[14]   <= d_ce[7:4];
            ent_r.dig[15]   <= d_ce[3:0];
            ent_r.has_frac  <= has_frac_r;
            state_r         <= ST_OUT;
          end
          ST_OUT: begin
            if (ent_ready) state_r <= ST_IDLE;
          end
          default: state_r <= ST_IDLE;
        endcase
      end
    end
  end

  assign in_ready  = !hold_v_r;
  assign ent_valid = (state_r == ST_OUT);
  assign ent       = ent_r;

endmodule

>>> src/isotf_queue.sv
// Small request queue between the decode front end and the character back end.
module isotf_queue #(
  parameter int unsigned DEPTH = isotf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  isotf_pkg::entry_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output isotf_pkg::entry_t pop_data
);
  import isotf_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          push;
  logic          pop;

  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      count_r <= count_r + CW'(push) - CW'(pop);
    end
  end

endmodule

>>> src/isotf_back.sv
// Back end: walks one decoded request and emits its text one character per cycle while out_ready is high.
module isotf_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         ent_valid,
  output logic                         ent_ready,
  input  isotf_pkg::entry_t            ent,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [isotf_pkg::CHAR_W-1:0] out_text_char,
  output logic                         out_last_char
);
  import isotf_pkg::*;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_DASH  = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_COLON = 7'h3A;
  localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2E;
  localparam logic [CHAR_W-1:0] CH_T     = 7'h54;
  localparam logic [CHAR_W-1:0] CH_Z     = 7'h5A;

  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;
  logic [4:0]        pos_r;

  logic              load;
  logic              is_dig;
  logic [3:0]        didx;
  logic [CHAR_W-1:0] sym;
  logic              last;
  logic [CHAR_W-1:0] ch;

  always_comb begin
    is_dig = 1'b0;
    didx   = '0;
    sym    = CH_Z;
    last   = 1'b0;
    case (pos_r) inside
      [5'd0:5'd3]:   begin is_dig = 1'b1; didx = pos_r[3:0]; end
      5'd4, 5'd7:    sym = CH_DASH;
      [5'd5:5'd6]:   begin is_dig = 1'b1; didx = 4'(pos_r - 5'd1); end
      [5'd8:5'd9]:   begin is_dig = 1'b1; didx = 4'(pos_r - 5'd2); end
      5'd10:         sym = CH_T;
      [5'd11:5'd12]: begin is_dig = 1'b1; didx = 4'(pos_r - 5'd3); end
      5'd13, 5'd16:  sym = CH_COLON;
      [5'd14:5'd15]: begin is_dig = 1'b1; didx = 4'(pos_r - 5'd4); end
      [5'd17:5'd18]: begin is_dig = 1'b1; didx = 4'(pos_r - 5'd5); end
      5'd19: begin
        if (ent.has_frac) begin
          sym = CH_DOT;
        end else begin
          sym  = CH_Z;
          last = 1'b1;
        end
      end
      [5'd20:5'd21]: begin is_dig = 1'b1; didx = 4'(pos_r - 5'd6); end
      default:       last = 1'b1;
    endcase
    ch = is_dig ? CH_ZERO + CHAR_W'(ent.dig[didx]) : sym;
  end

  assign load      = ent_valid && (!out_valid_r || out_ready);
  assign ent_ready = load && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        out_char_r  <= ch;
        out_last_r  <= last;
        pos_r       <= last ? 5'd0 : pos_r + 5'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_last_char = out_last_r;

endmodule

>>> src/iso8601_timestamp_formatter.sv
// Microsecond epoch count to ISO 8601 UTC text, one character per transfer on the output.
// Each timestamp runs through the radix-256 constant divider and then the decode/pack steps
// (YOE1, YOE2, DOY, MON, DIG, PACK); the input register can take the next timestamp meanwhile.
// Each timestamp gives 20 or 23 characters at one per cycle while out_ready is high.
// Reset: synchronous, active low; clears handshake state, queue pointers and the back end.
module iso8601_timestamp_formatter #(
  parameter int unsigned QUEUE_DEPTH = isotf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [isotf_pkg::USEC_W-1:0] in_epoch_usec,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [isotf_pkg::CHAR_W-1:0] out_text_char,
  output logic                         out_last_char
);
  import isotf_pkg::*;

  logic   f_valid;
  logic   f_ready;
  entry_t f_ent;
  logic   b_valid;
  logic   b_ready;
  entry_t b_ent;

  isotf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_epoch_usec (in_epoch_usec),
    .ent_valid     (f_valid),
    .ent_ready     (f_ready),
    .ent           (f_ent)
  );

  isotf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_ent),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_ent)
  );

  isotf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .ent_valid     (b_valid),
    .ent_ready     (b_ready),
    .ent           (b_ent),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char)
  );

endmodule

>>> dv/iso8601_timestamp_formatter_test.sv
`timescale 1ns / 100ps
// Self-checking test of the ISO 8601 timestamp formatter with a per-character scoreboard.

localparam logic [6:0] ASCII_ZERO  = 7'd48;
localparam logic [6:0] ASCII_DASH  = 7'h2d;
localparam logic [6:0] ASCII_T     = 7'h54;
localparam logic [6:0] ASCII_COLON = 7'h3a;
localparam logic [6:0] ASCII_DOT   = 7'h2e;
localparam logic [6:0] ASCII_Z     = 7'h5a;

localparam longint unsigned ONE_SEC_USEC   = 64'd1000000;
localparam longint unsigned USEC_PER_CENTI = 64'd10000;
localparam longint unsigned SEC_PER_DAY    = 64'd86400;
localparam longint unsigned LAST_USEC      = 64'd253402300799999999;

localparam int unsigned MAX_MISMATCH_REPORTS = 10;

typedef struct packed {
  logic [6:0] text_char;
  logic       last_char;
} ts_char_t;

class timestamp_scoreboard;
  ts_char_t    pending_chars[$];
  int unsigned mismatches;
  int unsigned requests;
  int unsigned chars_checked;
  int unsigned saturated;
  int unsigned fractional;

  function new();
    mismatches    = 0;
    requests      = 0;
    chars_checked = 0;
    saturated     = 0;
    fractional    = 0;
  endfunction

  function void push_char(logic [6:0] text_char, logic last_char);
    ts_char_t c;
    c.text_char = text_char;
    c.last_char = last_char;
    pending_chars.push_back(c);
  endfunction

  function void push_two_digits(longint unsigned v);
    push_char(ASCII_ZERO + 7'((v / 10) % 10), 1'b0);
    push_char(ASCII_ZERO + 7'(v % 10), 1'b0);
  endfunction

  // Days to civil date over 400-year eras counted from 0000-03-01.
  function void note_request(logic [57:0] epoch_usec);
    longint unsigned us, secs, frac, days, sod;
    longint unsigned z, era, doe, yoe, doy, mp, year, month, day;
    us = 64'(epoch_usec);
    requests++;
    if (us > LAST_USEC) begin
      us = LAST_USEC;
      saturated++;
    end
    secs  = us / ONE_SEC_USEC;
    frac  = us % ONE_SEC_USEC;
    days  = secs / SEC_PER_DAY;
    sod   = secs % SEC_PER_DAY;
    z     = days + 64'd719468;
    era   = z / 64'd146097;
    doe   = z - era * 64'd146097;
    yoe   = (doe - doe / 64'd1460 + doe / 64'd36524 - doe / 64'd146096) / 64'd365;
    doy   = doe - (64'd365 * yoe + yoe / 64'd4 - yoe / 64'd100);
    mp    = (64'd5 * doy + 64'd2) / 64'd153;
    year  = yoe + era * 64'd400;
    month = (mp < 64'd10) ? mp + 64'd3 : mp - 64'd9;
    day   = doy - (64'd153 * mp + 64'd2) / 64'd5 + 64'd1;
    if (month <= 64'd2) year++;
    push_two_digits((year / 100) % 100);
    push_two_digits(year % 100);
    push_char(ASCII_DASH, 1'b0);
    push_two_digits(month);
    push_char(ASCII_DASH, 1'b0);
    push_two_digits(day);
    push_char(ASCII_T, 1'b0);
    push_two_digits(sod / 3600);
    push_char(ASCII_COLON, 1'b0);
    push_two_digits((sod / 60) % 60);
    push_char(ASCII_COLON, 1'b0);
    push_two_digits(sod % 60);
    if (frac != 0) begin
      fractional++;
      push_char(ASCII_DOT, 1'b0);
      push_two_digits(frac / USEC_PER_CENTI);
    end
    push_char(ASCII_Z, 1'b1);
  endfunction

  function void check_char(logic [6:0] text_char, logic last_char);
    ts_char_t want;
    chars_checked++;
    if (pending_chars.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_MISMATCH_REPORTS)
        $display("char %0d: got 0x%02h last=%0b with nothing pending",
                 chars_checked, text_char, last_char);
      return;
    end
    want = pending_chars.pop_front();
    if (text_char !== want.text_char || last_char !== want.last_char) begin
      mismatches++;
      if (mismatches <= MAX_MISMATCH_REPORTS)
        $display("char %0d: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                 chars_checked, want.text_char, want.last_char, text_char, last_char);
    end
  endfunction
endclass

module iso8601_timestamp_formatter_test;
  import isotf_pkg::*;

  localparam int unsigned     RANDOM_REQUESTS = 100;
  localparam int unsigned     MAX_IDLE        = 11;
  localparam int unsigned     DRAIN_CYCLES    = 60;
  localparam longint unsigned CYCLE_LIMIT     = 200000;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_ready;
  logic [USEC_W-1:0] in_epoch_usec = '0;
  logic              out_valid;
  logic              out_ready     = 1'b0;
  logic [CHAR_W-1:0] out_text_char;
  logic              out_last_char;

  bit                  no_idle     = 1'b0;
  longint unsigned     cycle_count = 0;
  timestamp_scoreboard sb          = new();

  iso8601_timestamp_formatter dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_epoch_usec (in_epoch_usec),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int unsigned idle_cycles();
    return no_idle ? 0 : $urandom_range(MAX_IDLE, 0);
  endfunction

  task automatic send_request(input longint unsigned usec);
    logic [USEC_W-1:0] trimmed;
    int unsigned       gap;
    trimmed = USEC_W'(usec);
    gap = idle_cycles();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_epoch_usec <= trimmed;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_request(trimmed);
  endtask

  initial begin : char_sink
    int unsigned stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = idle_cycles();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      sb.check_char(out_text_char, out_last_char);
    end
  end

  initial begin : stimulus
    longint unsigned r, secs, usec;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(64'd0);
    send_request(64'd1);
    send_request(64'd9999);
    send_request(64'd10000);
    send_request(64'd999999);
    send_request(64'd1000000);
    send_request(64'd86399999999);
    send_request(64'd946684799000000);
    send_request(64'd951782400000000);
    send_request(64'd4107542399990000);
    send_request(64'd4107542400000000);
    send_request(64'd1735689599500000);
    send_request(64'd253402214400000000);
    send_request(LAST_USEC);
    send_request(LAST_USEC + 1);
    send_request(64'h0155_5555_5555_5555);
    send_request(64'h02AA_AAAA_AAAA_AAAA);
    send_request(64'h03FF_FFFF_FFFF_FFFF);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      no_idle = (i >= 30 && i < 50);
      if (i == 60) begin
        // hold off until the formatter has drained completely
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending_chars.size() != 0);
      end
      r    = {$urandom(), $urandom()};
      secs = r % (LAST_USEC / ONE_SEC_USEC + 1);
      case ($urandom_range(4, 0))
        0: usec = r;
        1: usec = secs * ONE_SEC_USEC;
        2: usec = secs * ONE_SEC_USEC + $urandom_range(9999, 1);
        3: usec = LAST_USEC - r % (SEC_PER_DAY * 400 * ONE_SEC_USEC);
        default: usec = secs * ONE_SEC_USEC + r % ONE_SEC_USEC;
      endcase
      send_request(usec);
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    while (sb.pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Formatted %0d timestamps: %0d saturated past year 9999, %0d with fraction.",
             sb.requests, sb.saturated, sb.fractional);
    $display("Checked %0d characters, %0d mismatches.", sb.chars_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_chars.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
